>>> rtl/core/bgr_to_hsv_pixel_assert.svh
// Assertion macros shared by the pixel converter RTL.
`ifndef BGR_TO_HSV_PIXEL_ASSERT_SVH
`define BGR_TO_HSV_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bhp_pkg.sv
// Types, constants and divider step function for the pixel converter.
package bhp_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned STEPS_PER  = 2;
    localparam int unsigned DIV_STAGES = PIX_W / STEPS_PER;

    localparam logic [PIX_W-1:0] HUE_GREEN_BASE = 8'd60;
    localparam logic [PIX_W-1:0] HUE_BLUE_BASE  = 8'd120;
    localparam logic [PIX_W-1:0] HUE_WRAP       = 8'd180;
    localparam logic [4:0]       HUE_SECTOR_SPAN = 5'd30;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] den;
        logic [PIX_W-1:0] nq;
    } t_div_lane;

    typedef struct packed {
        t_div_lane        sat;
        t_div_lane        hue;
        t_sector          sector;
        logic             neg;
        logic             grey;
        logic [PIX_W-1:0] brightness;
    } t_pipe_data;

    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic             qbit;
    } t_div_step;

    function automatic t_div_step div_step(
        input logic [PIX_W-1:0] rem,
        input logic             nbit,
        input logic [PIX_W-1:0] den
    );
        t_div_step      ret;
        logic [PIX_W:0] trial;
        logic [PIX_W:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            ret.rem  = diff[PIX_W-1:0];
            ret.qbit = 1'b1;
        end else begin
            ret.rem  = trial[PIX_W-1:0];
            ret.qbit = 1'b0;
        end
        return ret;
    endfunction

    function automatic t_div_lane div_lane_steps(input t_div_lane lane);
        t_div_lane ret;
        t_div_step st;
        ret = lane;
        for (int k = 0; k < STEPS_PER; k++) begin
            st      = div_step(ret.rem, ret.nq[PIX_W-1], ret.den);
            ret.rem = st.rem;
            ret.nq  = {ret.nq[PIX_W-2:0], st.qbit};
        end
        return ret;
    endfunction

endpackage

>>> rtl/core/bhp_if.sv
// Stream interfaces for the input pixel and the HSV result.
interface bhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink (input valid, input blue, input green, input red, output ready);
endinterface

interface bhp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

>>> rtl/core/bhp_prep.sv
// First stage: extremes, chroma, hue sector and divider operands.
module bhp_prep import bhp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_blue,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_red,
    output logic             o_valid,
    input  logic             i_ready,
    output t_pipe_data       o_data
);
    logic             r_valid;
    t_pipe_data       r_data;
    t_pipe_data       n_data;
    logic [PIX_W-1:0] mx;
    logic [PIX_W-1:0] mn;
    logic [PIX_W-1:0] delta;
    logic [PIX_W:0]   diff;
    logic [PIX_W-1:0] mag;
    logic [15:0]      hue_num;
    logic [15:0]      sat_num;
    t_sector          sector;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        delta = mx - mn;

        priority if (mx == i_red) begin
            sector = SEC_RED;
            diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (mx == i_green) begin
            sector = SEC_GREEN;
            diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            sector = SEC_BLUE;
            diff   = {1'b0, i_red} - {1'b0, i_green};
        end

        mag     = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
        hue_num = 16'(mag) * 16'(HUE_SECTOR_SPAN);
        sat_num = {delta, 8'd0} - 16'(delta);

        n_data.sat.rem    = sat_num[15:8];
        n_data.sat.nq     = sat_num[7:0];
        n_data.sat.den    = mx;
        n_data.hue.rem    = hue_num[15:8];
        n_data.hue.nq     = hue_num[7:0];
        n_data.hue.den    = delta;
        n_data.sector     = sector;
        n_data.neg        = diff[PIX_W];
        n_data.grey       = (delta == '0);
        n_data.brightness = mx;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/core/bhp_div_stage.sv
// One stage of the two restoring dividers, two quotient bits per transaction.
module bhp_div_stage import bhp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_pipe_data i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_pipe_data o_data
);
    logic       r_valid;
    t_pipe_data r_data;
    t_pipe_data n_data;

    always_comb begin
        n_data     = i_data;
        n_data.sat = div_lane_steps(i_data.sat);
        n_data.hue = div_lane_steps(i_data.hue);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> rtl/core/bhp_finish.sv
// Last stage: hue from sector and quotient, saturation clamp, output register.
module bhp_finish import bhp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_pipe_data       i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_hue,
    output logic [PIX_W-1:0] o_saturation,
    output logic [PIX_W-1:0] o_brightness
);
    logic             r_valid;
    logic [PIX_W-1:0] r_hue;
    logic [PIX_W-1:0] r_sat;
    logic [PIX_W-1:0] r_bright;
    logic [PIX_W-1:0] n_hue;
    logic [PIX_W-1:0] n_sat;
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] quo;
    logic             inexact;

    always_comb begin
        quo     = i_data.hue.nq;
        inexact = (i_data.hue.rem != '0);
        unique case (i_data.sector)
            SEC_RED:   base = i_data.neg ? HUE_WRAP : '0;
            SEC_GREEN: base = HUE_GREEN_BASE;
            SEC_BLUE:  base = HUE_BLUE_BASE;
            default:   base = '0;
        endcase

        // A negative offset is floored, so the quotient is rounded up.
        if (i_data.grey) begin
            n_hue = '0;
        end else if (i_data.neg) begin
            n_hue = base - quo - PIX_W'(inexact);
        end else begin
            n_hue = base + quo;
        end

        n_sat = (i_data.brightness == '0) ? '0 : i_data.sat.nq;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= i_data.brightness;
        end
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;
endmodule

>>> rtl/core/bgr_to_hsv_pixel.sv
// Top level of the pipelined blue-green-red to hue-saturation-value converter.
//
//   Channel   Direction   Payload
//   i_pix     in          blue, green, red (8 bits each)
//   o_hsv     out         hue (0..179), saturation, brightness (8 bits each)
//
// One transaction enters per clock unless a stall on o_hsv has backed up to the input.
// The pipeline has one operand stage, four divider stages that each resolve two
// quotient bits of both dividers, and one output register stage.
// Reset clears every stage's valid bit; the data registers are not reset.
// A stall on o_hsv holds the filled stages and empty stages keep filling, so no
// transaction is dropped or repeated.
module bgr_to_hsv_pixel import bhp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bhp_in_if.sink     i_pix,
    bhp_out_if.source  o_hsv
);
    `include "bgr_to_hsv_pixel_assert.svh"

    logic       stg_valid [DIV_STAGES+1];
    logic       stg_ready [DIV_STAGES+1];
    t_pipe_data stg_data  [DIV_STAGES+1];

    bhp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_blue  (i_pix.blue),
        .i_green (i_pix.green),
        .i_red   (i_pix.red),
        .o_valid (stg_valid[0]),
        .i_ready (stg_ready[0]),
        .o_data  (stg_data[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        bhp_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[s]),
            .o_ready (stg_ready[s]),
            .i_data  (stg_data[s]),
            .o_valid (stg_valid[s+1]),
            .i_ready (stg_ready[s+1]),
            .o_data  (stg_data[s+1])
        );
    end

    bhp_finish u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (stg_valid[DIV_STAGES]),
        .o_ready      (stg_ready[DIV_STAGES]),
        .i_data       (stg_data[DIV_STAGES]),
        .o_valid      (o_hsv.valid),
        .i_ready      (o_hsv.ready),
        .o_hue        (o_hsv.hue),
        .o_saturation (o_hsv.saturation),
        .o_brightness (o_hsv.brightness)
    );

    `BHP_ASSERT_SAME(a_hue_range, i_clk, i_rst_n, o_hsv.valid, o_hsv.hue <= 8'd179,
        "Hue is outside its range.")
    `BHP_ASSERT_SAME(a_black_pixel, i_clk, i_rst_n,
        o_hsv.valid && (o_hsv.brightness == 8'd0),
        (o_hsv.saturation == 8'd0) && (o_hsv.hue == 8'd0),
        "A black pixel has nonzero hue or saturation.")
    `BHP_ASSERT_SAME(a_grey_hue, i_clk, i_rst_n,
        o_hsv.valid && (o_hsv.saturation == 8'd0), o_hsv.hue == 8'd0,
        "A pixel without saturation has nonzero hue.")
    `BHP_ASSERT_SAME(a_empty_ready, i_clk, i_rst_n, !o_hsv.valid, i_pix.ready,
        "The input is stalled while the output register is empty.")
    `BHP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_hsv.valid && !o_hsv.ready,
        o_hsv.valid && $stable(o_hsv.hue) && $stable(o_hsv.saturation)
            && $stable(o_hsv.brightness),
        "A stalled result changed before it was taken.")
endmodule
